// ===== design/assert_macros.svh =====
// ----------------------------------------------------------------------------
// Assertion macros
// Shared concurrent assertion helpers for the ACL learning switch.
// ----------------------------------------------------------------------------
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// Check an implication on every rising clock edge outside reset.
`define ALS_ASSERT(lbl, clk, rst, prop, msg) \
   lbl: assert property (@(posedge clk) disable iff (rst) (prop)) else $error(msg);

// Check a property on every rising clock edge, reset included.
`define ALS_ASSERT_ALWAYS(lbl, clk, prop, msg) \
   lbl: assert property (@(posedge clk) (prop)) else $error(msg);

`endif

// ===== design/als_pkg.sv =====
// ----------------------------------------------------------------------------
// als_pkg
// Types and constants for the ACL learning switch.
// ----------------------------------------------------------------------------
package als_pkg;

   localparam int MAC_ENTRIES_DEF = 256;
   localparam int ACL_ENTRIES_DEF = 1024;

   localparam logic [15:0] ETH_IPV4 = 16'h0800;
   localparam int          GROUP_BIT = 40;

   localparam int REQ_DATA_W = 160;
   localparam int RSP_DATA_W = 24;

   typedef enum logic [1:0] {
      ACT_FORWARD = 2'd0,
      ACT_FLOOD   = 2'd1,
      ACT_DROP    = 2'd2,
      ACT_CTRL    = 2'd3
   } action_type;

   typedef enum logic [2:0] {
      ST_IDLE,
      ST_ACL_SCAN,
      ST_SRC_SCAN,
      ST_DST_SCAN,
      ST_PORT_GET,
      ST_OUT
   } state_type;

endpackage

// ===== design/als_ram.sv =====
// ----------------------------------------------------------------------------
// als_ram
// Generic single-write, single-read synchronous RAM with registered read.
// ----------------------------------------------------------------------------
module als_ram #(
   parameter int WIDTH = 32,
   parameter int DEPTH = 256
) (
   input  logic                     clock,
   input  logic                     wr_en,
   input  logic [$clog2(DEPTH)-1:0] wr_addr,
   input  logic [WIDTH-1:0]         wr_data,
   input  logic [$clog2(DEPTH)-1:0] rd_addr,
   output logic [WIDTH-1:0]         rd_data
);

   logic [WIDTH-1:0] mem [DEPTH];
   logic [WIDTH-1:0] rd_data_ff;

   // write and registered read
   always_ff @(posedge clock) begin
      if (wr_en) begin
         mem[wr_addr] <= wr_data;
      end
      rd_data_ff <= mem[rd_addr];
   end

   assign rd_data = rd_data_ff;

endmodule

// ===== design/acl_learning_switch.sv =====
// ----------------------------------------------------------------------------
// acl_learning_switch
// Learning switch with a source IPv4 allow list, tables in synchronous RAM.
// ----------------------------------------------------------------------------
// channel | dir | tdata                                   | tuser
// req     | in  | eth_type,src_mac,dst_mac,in_port,ip_src | req_type
// rsp     | out | action,fwd_port,notify_valid/allowed,full | -
//
// Each table lookup scans the filled entries through one RAM read port, one
// entry per cycle. Reset clears the fill counts only; no clearing pass.
// A stalled result holds the block in its output state until taken.
// ----------------------------------------------------------------------------
`include "assert_macros.svh"

module acl_learning_switch #(
   parameter int MAC_ENTRIES = als_pkg::MAC_ENTRIES_DEF,
   parameter int ACL_ENTRIES = als_pkg::ACL_ENTRIES_DEF
) (
   input  logic                          clock,
   input  logic                          reset,
   input  logic                          req_tvalid,
   output logic                          req_tready,
   // eth_type[15:0] src_mac[63:16] dst_mac[111:64] in_port[127:112] ip_src[159:128]
   input  logic [als_pkg::REQ_DATA_W-1:0] req_tdata,
   // req_type[0]
   input  logic                          req_tuser,
   output logic                          rsp_tvalid,
   input  logic                          rsp_tready,
   // action[1:0] fwd_port[17:2] notify_valid[18] notify_allowed[19] table_full[20]
   output logic [als_pkg::RSP_DATA_W-1:0] rsp_tdata
);

   localparam int MAC_AW = $clog2(MAC_ENTRIES);
   localparam int ACL_AW = $clog2(ACL_ENTRIES);
   localparam int MAC_CW = $clog2(MAC_ENTRIES + 1);
   localparam int ACL_CW = $clog2(ACL_ENTRIES + 1);
   localparam int SW     = (MAC_CW > ACL_CW) ? MAC_CW : ACL_CW;

   als_pkg::state_type state_ff, state_in;

   // captured word
   logic        ctrl_ff;
   logic [15:0] etype_ff;
   logic [47:0] smac_ff, dmac_ff;
   logic [15:0] port_ff;
   logic [31:0] ip_ff;

   // result register
   als_pkg::action_type act_ff, act_in;
   logic [15:0] oport_ff, oport_in;
   logic        nv_ff, nv_in, na_ff, na_in, full_ff, full_in;

   // fill counts and scan
   logic [MAC_CW-1:0] mac_cnt_ff, mac_cnt_in;
   logic [ACL_CW-1:0] acl_cnt_ff, acl_cnt_in;
   logic [SW-1:0]     idx_ff, idx_in, pidx_ff, pidx_in, scan_cnt;
   logic              pend_ff, pend_in;
   logic              scanning, match, hit, more, done;

   // memory ports
   logic              acl_we, key_we, mp_we;
   logic [ACL_AW-1:0] acl_waddr;
   logic [MAC_AW-1:0] key_waddr, mp_waddr;
   logic [31:0]       acl_rdata;
   logic [47:0]       key_rdata;
   logic [15:0]       mp_rdata;

   logic acc, mac_full, acl_full, in_ipv4, in_ctrl;

   assign acc      = req_tvalid && req_tready;
   assign in_ctrl  = req_tuser;
   assign in_ipv4  = (req_tdata[15:0] == als_pkg::ETH_IPV4);
   assign mac_full = (mac_cnt_ff == MAC_CW'(MAC_ENTRIES));
   assign acl_full = (acl_cnt_ff == ACL_CW'(ACL_ENTRIES));

   als_ram #(.WIDTH(32), .DEPTH(ACL_ENTRIES)) u_acl_ram (
      .clock(clock), .wr_en(acl_we), .wr_addr(acl_waddr), .wr_data(ip_ff),
      .rd_addr(idx_ff[ACL_AW-1:0]), .rd_data(acl_rdata));

   als_ram #(.WIDTH(48), .DEPTH(MAC_ENTRIES)) u_key_ram (
      .clock(clock), .wr_en(key_we), .wr_addr(key_waddr), .wr_data(smac_ff),
      .rd_addr(idx_ff[MAC_AW-1:0]), .rd_data(key_rdata));

   als_ram #(.WIDTH(16), .DEPTH(MAC_ENTRIES)) u_port_ram (
      .clock(clock), .wr_en(mp_we), .wr_addr(mp_waddr), .wr_data(port_ff),
      .rd_addr(pidx_ff[MAC_AW-1:0]), .rd_data(mp_rdata));

   // scan compare against the entry read last cycle
   always_comb begin
      scanning = 1'b0;
      scan_cnt = SW'(mac_cnt_ff);
      match    = 1'b0;
      unique case (state_ff)
         als_pkg::ST_ACL_SCAN: begin
            scanning = 1'b1;
            scan_cnt = SW'(acl_cnt_ff);
            match    = (acl_rdata == ip_ff);
         end
         als_pkg::ST_SRC_SCAN: begin
            scanning = 1'b1;
            match    = (key_rdata == smac_ff);
         end
         als_pkg::ST_DST_SCAN: begin
            scanning = 1'b1;
            match    = (key_rdata == dmac_ff);
         end
         default: begin
            scanning = 1'b0;
         end
      endcase
      hit  = pend_ff && match;
      more = (idx_ff < scan_cnt);
      done = hit || (!pend_ff && !more);
   end

   // next state
   always_comb begin
      state_in = state_ff;
      unique case (state_ff)
         als_pkg::ST_IDLE: begin
            if (acc) begin
               if (in_ctrl || in_ipv4) begin
                  state_in = als_pkg::ST_ACL_SCAN;
               end else if (!req_tdata[16 + als_pkg::GROUP_BIT]) begin
                  state_in = als_pkg::ST_SRC_SCAN;
               end else if (!req_tdata[64 + als_pkg::GROUP_BIT]) begin
                  state_in = als_pkg::ST_DST_SCAN;
               end else begin
                  state_in = als_pkg::ST_OUT;
               end
            end
         end
         als_pkg::ST_ACL_SCAN: begin
            if (done) begin
               if (ctrl_ff || !hit) begin
                  state_in = als_pkg::ST_OUT;
               end else if (!smac_ff[als_pkg::GROUP_BIT]) begin
                  state_in = als_pkg::ST_SRC_SCAN;
               end else if (!dmac_ff[als_pkg::GROUP_BIT]) begin
                  state_in = als_pkg::ST_DST_SCAN;
               end else begin
                  state_in = als_pkg::ST_OUT;
               end
            end
         end
         als_pkg::ST_SRC_SCAN: begin
            if (done) begin
               state_in = dmac_ff[als_pkg::GROUP_BIT] ? als_pkg::ST_OUT
                                                      : als_pkg::ST_DST_SCAN;
            end
         end
         als_pkg::ST_DST_SCAN: begin
            if (done) begin
               state_in = hit ? als_pkg::ST_PORT_GET : als_pkg::ST_OUT;
            end
         end
         als_pkg::ST_PORT_GET: state_in = als_pkg::ST_OUT;
         als_pkg::ST_OUT: begin
            if (rsp_tready) begin
               state_in = als_pkg::ST_IDLE;
            end
         end
         default: state_in = als_pkg::ST_IDLE;
      endcase
   end

   // outputs, table writes and result fields
   always_comb begin
      req_tready = (state_ff == als_pkg::ST_IDLE);
      rsp_tvalid = (state_ff == als_pkg::ST_OUT);
      acl_we     = 1'b0;
      acl_waddr  = acl_cnt_ff[ACL_AW-1:0];
      key_we     = 1'b0;
      key_waddr  = mac_cnt_ff[MAC_AW-1:0];
      mp_we      = 1'b0;
      mp_waddr   = mac_cnt_ff[MAC_AW-1:0];
      mac_cnt_in = mac_cnt_ff;
      acl_cnt_in = acl_cnt_ff;
      act_in     = act_ff;
      oport_in   = oport_ff;
      nv_in      = nv_ff;
      na_in      = na_ff;
      full_in    = full_ff;
      // advance the scan, or clear it between scans
      if (scanning && !done) begin
         pend_in = more;
         pidx_in = idx_ff;
         idx_in  = more ? idx_ff + SW'(1) : idx_ff;
      end else begin
         pend_in = 1'b0;
         pidx_in = hit ? pidx_ff : '0;
         idx_in  = '0;
      end
      unique case (state_ff)
         als_pkg::ST_IDLE: begin
            if (acc) begin
               act_in   = in_ctrl ? als_pkg::ACT_CTRL : als_pkg::ACT_FLOOD;
               oport_in = '0;
               nv_in    = !in_ctrl && in_ipv4;
               na_in    = 1'b0;
               full_in  = 1'b0;
            end
         end
         als_pkg::ST_ACL_SCAN: begin
            if (done) begin
               if (ctrl_ff) begin
                  // add a new address, refuse when full
                  if (!hit) begin
                     if (acl_full) begin
                        full_in = 1'b1;
                     end else begin
                        acl_we     = 1'b1;
                        acl_cnt_in = acl_cnt_ff + ACL_CW'(1);
                     end
                  end
               end else if (hit) begin
                  na_in = 1'b1;
               end else begin
                  act_in = als_pkg::ACT_DROP;
               end
            end
         end
         als_pkg::ST_SRC_SCAN: begin
            if (done) begin
               // overwrite a known source, append a new one, refuse when full
               if (hit) begin
                  mp_we    = 1'b1;
                  mp_waddr = pidx_ff[MAC_AW-1:0];
               end else if (mac_full) begin
                  full_in = 1'b1;
               end else begin
                  mp_we      = 1'b1;
                  key_we     = 1'b1;
                  mac_cnt_in = mac_cnt_ff + MAC_CW'(1);
               end
            end
         end
         als_pkg::ST_PORT_GET: begin
            act_in   = als_pkg::ACT_FORWARD;
            oport_in = mp_rdata;
         end
         default: begin
            act_in = act_ff;
         end
      endcase
   end

   assign rsp_tdata = {3'b000, full_ff, na_ff, nv_ff, oport_ff, act_ff};

   // control registers
   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff   <= als_pkg::ST_IDLE;
         mac_cnt_ff <= '0;
         acl_cnt_ff <= '0;
         pend_ff    <= 1'b0;
         idx_ff     <= '0;
      end else begin
         state_ff   <= state_in;
         mac_cnt_ff <= mac_cnt_in;
         acl_cnt_ff <= acl_cnt_in;
         pend_ff    <= pend_in;
         idx_ff     <= idx_in;
      end
   end

   // payload registers
   always_ff @(posedge clock) begin
      pidx_ff  <= pidx_in;
      act_ff   <= act_in;
      oport_ff <= oport_in;
      nv_ff    <= nv_in;
      na_ff    <= na_in;
      full_ff  <= full_in;
      if (acc) begin
         ctrl_ff  <= req_tuser;
         etype_ff <= req_tdata[15:0];
         smac_ff  <= req_tdata[63:16];
         dmac_ff  <= req_tdata[111:64];
         port_ff  <= req_tdata[127:112];
         ip_ff    <= req_tdata[159:128];
      end
   end

   `ALS_ASSERT(a_mac_cnt_max, clock, reset, mac_cnt_ff <= MAC_CW'(MAC_ENTRIES), "mac fill over depth")
   `ALS_ASSERT(a_acl_cnt_max, clock, reset, acl_cnt_ff <= ACL_CW'(ACL_ENTRIES), "acl fill over depth")
   `ALS_ASSERT(a_busy_excl, clock, reset, !(rsp_tvalid && req_tready), "accept while result pending")
   `ALS_ASSERT(a_mac_step, clock, reset, mac_cnt_ff != mac_cnt_in |-> state_ff == als_pkg::ST_SRC_SCAN && !full_in, "mac fill moved outside learn")
   `ALS_ASSERT(a_nv_ipv4, clock, reset, rsp_tvalid && nv_ff |-> etype_ff == als_pkg::ETH_IPV4 && !ctrl_ff, "notice without ipv4")

endmodule
